// ===== rtl/ctq_pkg.sv =====
// Package for the connection timeout queue: command codes, controller states,
// and the command/status structs between controller and datapath.
// No dependencies.
package ctq_pkg;

	localparam int DEF_QUEUE_DEPTH = 64;
	localparam int DEF_TIME_BITS   = 32;
	localparam int WAIT_BITS       = 17;
	localparam logic [WAIT_BITS-1:0] WAIT_RESET = 17'd20;

	// input command codes
	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_DEL  = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// configuration register indexes
	localparam logic CFG_WAIT = 1'b0;
	localparam logic CFG_DROP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_DEL,
		ST_TICK_CHK,
		ST_TICK_POP,
		ST_TICK_INS
	} ctq_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_item;  // capture the accepted input item
		logic do_insert;  // sorted insert at now + wait
		logic ins_head;   // insert the popped head instead of the item
		logic rm_head;    // remove cell 0 (tick pop)
		logic rm_match;   // remove first cell of the item's connection
		logic load_rem;   // load count of due entries
		logic out_load;   // load the output register
		logic out_full;   // output is a table-full rejection
	} ctq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic head_due;
		logic match_found;
		logic rem_one;
		logic rem_zero;
		logic out_free;
		logic drop;
	} ctq_sts_t;

endpackage

// ===== rtl/ctq_ctrl.sv =====
// Controller state machine of the connection timeout queue.
// Depends on ctq_pkg.
module ctq_ctrl import ctq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_cmd,
	output logic       in_ready,
	input  ctq_sts_t   sts,
	output ctq_cmd_t   cmd
);

	ctq_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					case (in_cmd)
						CMD_ADD:  state_d = ST_ADD;
						CMD_DEL:  state_d = ST_DEL;
						CMD_TICK: state_d = ST_TICK_CHK;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				if (sts.full) begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_full = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.do_insert = 1'b1;
					state_d = ST_IDLE;
				end
			end
			// one matching entry removed per cycle
			ST_DEL: begin
				if (sts.match_found) begin
					cmd.rm_match = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TICK_CHK: begin
				if (sts.head_due) begin
					cmd.load_rem = 1'b1;
					state_d = ST_TICK_POP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TICK_POP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.rm_head  = 1'b1;
					if (!sts.drop) begin
						state_d = ST_TICK_INS;
					end else if (sts.rem_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_TICK_INS: begin
				cmd.do_insert = 1'b1;
				cmd.ins_head  = 1'b1;
				state_d = sts.rem_zero ? ST_IDLE : ST_TICK_POP;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/ctq_datapath.sv =====
// Datapath of the connection timeout queue: sorted cell chain, config
// registers, item and head capture, and the output register. Depends on ctq_pkg.
module ctq_datapath import ctq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int TIME_BITS   = DEF_TIME_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic [WAIT_BITS-1:0] cfg_data,
	input  logic [79:0]          in_data,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [55:0]          m_tdata,
	output logic                 m_tlast,
	input  ctq_cmd_t             cmd,
	output ctq_sts_t             sts
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = ((TIME_BITS > WAIT_BITS) ? TIME_BITS : WAIT_BITS) + 1;

	logic [WAIT_BITS-1:0] wait_q;
	logic                 drop_q;

	logic [TIME_BITS-1:0] exp_q  [QUEUE_DEPTH];
	logic [15:0]          conn_q [QUEUE_DEPTH];
	logic [31:0]          seq_q  [QUEUE_DEPTH];
	logic [CW-1:0]        count_q;

	logic [15:0]          item_conn_q;
	logic [31:0]          item_seq_q;
	logic [TIME_BITS-1:0] item_now_q;
	logic [15:0]          hd_conn_q;
	logic [31:0]          hd_seq_q;
	logic [CW-1:0]        rem_q;

	logic                 out_valid_q;
	logic [55:0]          out_data_q;
	logic                 out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= WAIT_RESET;
			drop_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_WAIT: wait_q <= cfg_data;
				CFG_DROP: drop_q <= cfg_data[0];
				default:  wait_q <= wait_q;
			endcase
		end
	end

	// re-arm / add time: now + wait, saturating
	logic [SW-1:0]        sum;
	logic [TIME_BITS-1:0] ins_t;
	assign sum   = SW'(item_now_q) + SW'(wait_q);
	assign ins_t = (sum[SW-1:TIME_BITS] != '0) ? '1 : sum[TIME_BITS-1:0];

	logic [15:0] ins_conn;
	logic [31:0] ins_seq;
	assign ins_conn = cmd.ins_head ? hd_conn_q : item_conn_q;
	assign ins_seq  = cmd.ins_head ? hd_seq_q  : item_seq_q;

	// per-cell compares
	logic [QUEUE_DEPTH-1:0] vld, gt, mt;
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			vld[i] = CW'(i) < count_q;
			gt[i]  = vld[i] && (exp_q[i] > ins_t);
			mt[i]  = vld[i] && (conn_q[i] == item_conn_q);
		end
	end

	// due count and first matching cell
	logic [CW-1:0] due_cnt;
	logic [IW-1:0] match_idx;
	logic          match_found;
	always_comb begin
		due_cnt     = count_q;
		match_idx   = '0;
		match_found = 1'b0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (vld[i] && (exp_q[i] > item_now_q)) due_cnt = CW'(i);
			if (mt[i]) begin
				match_found = 1'b1;
				match_idx   = IW'(i);
			end
		end
	end

	logic          rm_en;
	logic [IW-1:0] rm_idx;
	assign rm_en  = cmd.rm_head | cmd.rm_match;
	assign rm_idx = cmd.rm_head ? '0 : match_idx;

	// cell chain: shift right on insert, shift left on remove
	genvar gi;
	for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
		logic                 up_sel;
		logic                 dn_ok;
		logic [TIME_BITS-1:0] up_exp, dn_exp;
		logic [15:0]          up_conn, dn_conn;
		logic [31:0]          up_seq, dn_seq;
		if (gi == 0) begin : g_first
			assign up_sel  = 1'b0;
			assign up_exp  = exp_q[0];
			assign up_conn = conn_q[0];
			assign up_seq  = seq_q[0];
		end else begin : g_mid
			assign up_sel  = gt[gi-1];
			assign up_exp  = exp_q[gi-1];
			assign up_conn = conn_q[gi-1];
			assign up_seq  = seq_q[gi-1];
		end
		if (gi == QUEUE_DEPTH - 1) begin : g_last
			assign dn_ok   = 1'b0;
			assign dn_exp  = exp_q[gi];
			assign dn_conn = conn_q[gi];
			assign dn_seq  = seq_q[gi];
		end else begin : g_nlast
			assign dn_ok   = 1'b1;
			assign dn_exp  = exp_q[gi+1];
			assign dn_conn = conn_q[gi+1];
			assign dn_seq  = seq_q[gi+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.do_insert) begin
				if (up_sel) begin
					exp_q[gi]  <= up_exp;
					conn_q[gi] <= up_conn;
					seq_q[gi]  <= up_seq;
				end else if (gt[gi] || (CW'(gi) == count_q)) begin
					exp_q[gi]  <= ins_t;
					conn_q[gi] <= ins_conn;
					seq_q[gi]  <= ins_seq;
				end
			end else if (rm_en && dn_ok && (IW'(gi) >= rm_idx)) begin
				exp_q[gi]  <= dn_exp;
				conn_q[gi] <= dn_conn;
				seq_q[gi]  <= dn_seq;
			end
		end
	end

	// fill count and due counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			if (cmd.do_insert) count_q <= count_q + CW'(1);
			else if (rm_en)    count_q <= count_q - CW'(1);
			if (cmd.load_rem)     rem_q <= due_cnt;
			else if (cmd.rm_head) rem_q <= rem_q - CW'(1);
		end
	end

	// item and popped head capture
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_conn_q <= in_data[15:0];
			item_seq_q  <= in_data[47:16];
			item_now_q  <= TIME_BITS'(in_data[79:48]);
		end
		if (cmd.rm_head) begin
			hd_conn_q <= conn_q[0];
			hd_seq_q  <= seq_q[0];
		end
	end

	// output register
	logic [CW-1:0] used;
	assign used = (drop_q && !cmd.out_full) ? count_q - CW'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_full) begin
				out_data_q <= {7'(used), 32'd0, 16'd0, 1'b1};
				out_last_q <= 1'b1;
			end else begin
				out_data_q <= {7'(used), seq_q[0], conn_q[0], 1'b0};
				out_last_q <= (rem_q == CW'(1));
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// status to controller
	assign sts.full        = (count_q == CW'(QUEUE_DEPTH));
	assign sts.head_due    = (count_q != '0) && (exp_q[0] < item_now_q);
	assign sts.match_found = match_found;
	assign sts.rem_one     = (rem_q == CW'(1));
	assign sts.rem_zero    = (rem_q == '0);
	assign sts.out_free    = !out_valid_q || m_tready;
	assign sts.drop        = drop_q;

endmodule

// ===== rtl/connection_timeout_queue_top.sv =====
// Channel  | signals                         | payload
// s_*      | s_tvalid s_tready s_tdata s_tuser | command, conn_id, sequence_req, now
// m_*      | m_tvalid m_tready m_tdata m_tlast | status, out_conn, out_sequence, entries_in_use
// cfg_*    | cfg_we cfg_idx cfg_data           | wait_seconds (0), drop_on_expiry (1)
//
// One item at a time. Add: sorted insert, or a table-full rejection once the output is free.
// Delete: one matching entry removed per cycle until none is left. Tick: head check, then per due
// entry a pop (drop) or a pop then a sorted insert into the cell chain (re-arm); output stalls hold pops.
// Reset clears count and config; cell contents are not reset.
// Depends on ctq_pkg, ctq_ctrl, ctq_datapath.
module connection_timeout_queue_top import ctq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int TIME_BITS   = DEF_TIME_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic [WAIT_BITS-1:0] cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [79:0]          s_tdata,  // conn_id, sequence_req, now
	input  logic [1:0]           s_tuser,  // command
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [55:0]          m_tdata,  // status, out_conn, out_sequence, entries_in_use
	output logic                 m_tlast
);

	ctq_cmd_t cmd;
	ctq_sts_t sts;

	ctq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_cmd   (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ctq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_data  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.sts      (sts)
	);

	// output register only loaded when it is free
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output overwritten");

	// never insert into a full chain
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_insert |-> !sts.full)
		else $error("insert into full table");

	// delete only removes a real match
	a_del_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rm_match |-> sts.match_found)
		else $error("delete without match");

endmodule

// ===== test/ctq_checker.sv =====
// Checker for the connection timeout queue: tracks config writes and input
// items, predicts the result items and compares them with the m_* channel.
// Depends on ctq_pkg.
module ctq_checker import ctq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic [WAIT_BITS-1:0] cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [79:0]          s_tdata,  // conn_id, sequence_req, now
	input  logic [1:0]           s_tuser,  // command
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [55:0]          m_tdata,  // status, out_conn, out_sequence, entries_in_use
	input  logic                 m_tlast,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = DEF_QUEUE_DEPTH;
	localparam int RING  = 256;

	typedef struct packed {
		logic        status;
		logic [15:0] conn;
		logic [31:0] seq;
		logic [6:0]  used;
		logic        last;
	} timeout_result_t;

	// predicted table, sorted by deadline
	logic [31:0]          deadline_tbl[DEPTH];
	logic [15:0]          conn_tbl[DEPTH];
	logic [31:0]          seq_tbl[DEPTH];
	int                   n_entries;
	logic [WAIT_BITS-1:0] wait_s;
	logic                 drop_mode;

	// expected result items, oldest at ring_head
	timeout_result_t      exp_ring[RING];
	logic [7:0]           ring_head;
	logic [7:0]           ring_tail;
	int                   ring_count;

	assign pending = ring_count;

	function automatic void add_expected(timeout_result_t r);
		exp_ring[ring_tail] = r;
		ring_tail++;
		ring_count++;
	endfunction

	function automatic logic [31:0] deadline_of(logic [31:0] now);
		logic [32:0] sum;
		sum = {1'b0, now} + {16'd0, wait_s};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// insert after all entries with deadline <= t
	function automatic void sorted_insert(logic [31:0] t, logic [15:0] c, logic [31:0] s);
		int pos;
		pos = n_entries;
		while (pos > 0 && deadline_tbl[pos-1] > t) begin
			deadline_tbl[pos] = deadline_tbl[pos-1];
			conn_tbl[pos] = conn_tbl[pos-1];
			seq_tbl[pos] = seq_tbl[pos-1];
			pos--;
		end
		deadline_tbl[pos] = t;
		conn_tbl[pos] = c;
		seq_tbl[pos] = s;
		n_entries++;
	endfunction

	function automatic void predict_item(logic [1:0] cmd, logic [15:0] conn,
			logic [31:0] seq, logic [31:0] now);
		logic [15:0] due_c[DEPTH];
		logic [31:0] due_s[DEPTH];
		timeout_result_t r;
		int k, w, start;
		logic [31:0] t;
		case (cmd)
			CMD_ADD: begin
				if (n_entries >= DEPTH) begin
					r = '{1'b1, 16'd0, 32'd0, 7'(n_entries), 1'b1};
					add_expected(r);
				end else begin
					sorted_insert(deadline_of(now), conn, seq);
				end
			end
			CMD_DEL: begin
				w = 0;
				for (int i = 0; i < n_entries; i++) begin
					if (conn_tbl[i] != conn) begin
						deadline_tbl[w] = deadline_tbl[i];
						conn_tbl[w] = conn_tbl[i];
						seq_tbl[w] = seq_tbl[i];
						w++;
					end
				end
				n_entries = w;
			end
			CMD_TICK: begin
				if (n_entries != 0 && deadline_tbl[0] < now) begin
					k = 0;
					while (k < n_entries && deadline_tbl[k] <= now) begin
						due_c[k] = conn_tbl[k];
						due_s[k] = seq_tbl[k];
						k++;
					end
					start = n_entries;
					for (int i = k; i < n_entries; i++) begin
						deadline_tbl[i-k] = deadline_tbl[i];
						conn_tbl[i-k] = conn_tbl[i];
						seq_tbl[i-k] = seq_tbl[i];
					end
					n_entries -= k;
					t = deadline_of(now);
					for (int i = 0; i < k; i++) begin
						r = '{1'b0, due_c[i], due_s[i],
							7'(drop_mode ? start - (i + 1) : start), i + 1 == k};
						add_expected(r);
						if (!drop_mode)
							sorted_insert(t, due_c[i], due_s[i]);
					end
				end
			end
			default: ;  // unused command code: ignored
		endcase
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	// track config, inputs and outputs at each rising edge
	always @(posedge clk or negedge arst_n) begin
		timeout_result_t exp_r;
		if (!arst_n) begin
			n_entries = 0;
			wait_s = WAIT_RESET;
			drop_mode = 1'b0;
			errors = 0;
			ring_head = '0;
			ring_tail = '0;
			ring_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (ring_count == 0) begin
					report("unexpected result item, tdata", m_tdata[31:0], 32'd0);
				end else begin
					exp_r = exp_ring[ring_head];
					ring_head++;
					ring_count--;
					if (m_tdata[0] !== exp_r.status)
						report("status", m_tdata[0], exp_r.status);
					if (m_tdata[16:1] !== exp_r.conn)
						report("out_conn", m_tdata[16:1], exp_r.conn);
					if (m_tdata[48:17] !== exp_r.seq)
						report("out_sequence", m_tdata[48:17], exp_r.seq);
					if (m_tdata[55:49] !== exp_r.used)
						report("entries_in_use", m_tdata[55:49], exp_r.used);
					if (m_tlast !== exp_r.last)
						report("last", m_tlast, exp_r.last);
				end
			end
			if (cfg_we) begin
				if (cfg_idx == CFG_WAIT)
					wait_s = cfg_data;
				else
					drop_mode = cfg_data[0];
			end
			if (s_tvalid && s_tready)
				predict_item(s_tuser, s_tdata[15:0], s_tdata[47:16], s_tdata[79:48]);
		end
	end

endmodule

// ===== test/tb_connection_timeout_queue_top.sv =====
// Testbench top for connection_timeout_queue_top: clock, reset, stimulus
// phases with idling and back-pressure, watchdog and verdict.
// Depends on ctq_pkg, connection_timeout_queue_top and ctq_checker.
module tb_connection_timeout_queue_top import ctq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 200;   // longest delete walk plus margin
	localparam int STALL_LIMIT  = 5000;  // cycles with no handshake at all

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic                 cfg_idx;
	logic [WAIT_BITS-1:0] cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [79:0]          s_tdata;  // conn_id, sequence_req, now
	logic [1:0]           s_tuser;  // command
	logic                 m_tvalid;
	logic                 m_tready;
	logic [55:0]          m_tdata;  // status, out_conn, out_sequence, entries_in_use
	logic                 m_tlast;
	int                   errors;
	int                   pending;

	int                   send_idle_pct;
	int                   recv_stall_pct;
	int                   hold_off;
	int                   quiet_cycles;
	logic [31:0]          clock_secs;
	logic [16:0]          cur_wait;

	connection_timeout_queue_top dut (.*);

	ctq_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// receiver: random stalls, or a counted hold-off when requested
	always @(negedge clk) begin
		if (hold_off > 0) begin
			m_tready = 1'b0;
			hold_off = hold_off - 1;
		end else begin
			m_tready = $urandom_range(0, 99) >= recv_stall_pct;
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// offer one item; returns at the falling edge after it was taken
	task automatic send_item(logic [1:0] cmd, logic [15:0] conn, logic [31:0] seq,
			logic [31:0] now);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = {now, seq, conn};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// wait for all results plus the block's own tail before touching config
	task automatic drain();
		s_tvalid = 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [WAIT_BITS-1:0] val);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_WAIT)
			cur_wait = val;
	endtask

	// connection ids: mostly a small pool so deletes and ties hit
	function automatic logic [15:0] pick_conn();
		if ($urandom_range(0, 99) < 80)
			return 16'($urandom_range(0, 7));
		return 16'($urandom);
	endfunction

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			send_item(CMD_ADD, pick_conn(), $urandom, clock_secs);
		end else if (r < 62) begin
			clock_secs = clock_secs + $urandom_range(0, 2 * cur_wait + 2);
			send_item(CMD_TICK, 16'($urandom), $urandom, clock_secs);
		end else if (r < 75) begin
			send_item(CMD_DEL, pick_conn(), $urandom, $urandom);
		end else if (r < 80) begin
			send_item(2'd3, 16'($urandom), $urandom, $urandom);
		end else begin
			// noise: any valid command, any time
			send_item(2'($urandom_range(0, 2)), 16'($urandom), $urandom, $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_WAIT;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tuser = CMD_ADD;
		s_tdata = '0;
		m_tready = 1'b0;
		hold_off = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		clock_secs = 32'd100;
		cur_wait = WAIT_RESET;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, ties, saturation, nothing-due ticks
		send_item(CMD_TICK, 16'd0, 32'd0, 32'd50);           // empty table
		send_item(CMD_ADD, 16'd0, 32'd0, 32'd0);
		send_item(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // saturated
		send_item(CMD_ADD, 16'd1, 32'h1234_5678, 32'd5);
		send_item(CMD_ADD, 16'd2, 32'h8765_4321, 32'd5);     // tie, insertion order
		send_item(CMD_ADD, 16'd1, 32'hA5A5_A5A5, 32'd3);
		send_item(CMD_TICK, 16'd0, 32'd0, 32'd20);           // head equals now
		send_item(CMD_TICK, 16'd0, 32'd0, 32'd25);           // several due
		send_item(2'd3, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(CMD_TICK, 16'd0, 32'd0, 32'd10);           // earliest in future
		send_item(CMD_TICK, 16'd0, 32'd0, 32'hFFFF_FFFF);    // re-arm saturates
		send_item(CMD_TICK, 16'd0, 32'd0, 32'hFFFF_FFFF);    // nothing strictly due
		send_item(CMD_DEL, 16'd7, 32'd0, 32'd0);             // no match
		send_item(CMD_DEL, 16'd1, 32'd0, 32'd0);
		send_item(CMD_DEL, 16'hFFFF, 32'd0, 32'd0);
		send_item(CMD_DEL, 16'd0, 32'd0, 32'd0);
		send_item(CMD_DEL, 16'd2, 32'd0, 32'd0);
		drain();

		// random phases: each its own idling mix and config
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_cfg(CFG_WAIT, 17'd1);
					write_cfg(CFG_DROP, 17'd0);
				end
				1: begin
					write_cfg(CFG_WAIT, 17'd86400);
					write_cfg(CFG_DROP, 17'd1);
				end
				2: begin
					write_cfg(CFG_WAIT, 17'd7);
					write_cfg(CFG_DROP, 17'd0);
				end
				default: begin
					write_cfg(CFG_WAIT, 17'($urandom_range(1, 30)));
					write_cfg(CFG_DROP, 17'd1);
				end
			endcase
			send_idle_pct = (ph == 1 || ph == 3) ? 48 : 0;
			recv_stall_pct = (ph >= 2) ? 48 : 0;
			if (ph == 3)
				send_idle_pct = 36;
			if (ph == 3)
				recv_stall_pct = 36;
			for (int i = 0; i < 65; i++) begin
				random_item();
				if (i == 32)
					drain();  // sender waits for every result mid-phase
			end
			drain();
		end

		// fill the table past full with the output held off, then tick twice with every entry due
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_cfg(CFG_WAIT, 17'd3);
		write_cfg(CFG_DROP, 17'd0);
		hold_off = 400;
		for (int i = 0; i < 70; i++)
			send_item(CMD_ADD, 16'($urandom), $urandom, clock_secs);
		send_item(CMD_TICK, 16'd0, 32'd0, clock_secs + 32'd10);
		send_item(CMD_TICK, 16'd0, 32'd0, clock_secs + 32'd20);
		drain();

		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== connection_timeout_queue_top.f =====
rtl/ctq_pkg.sv
rtl/ctq_ctrl.sv
rtl/ctq_datapath.sv
rtl/connection_timeout_queue_top.sv
test/ctq_checker.sv
test/tb_connection_timeout_queue_top.sv
